### rtl/core/bws_pkg.sv
// Package for the 5x5 box window sum block: field widths, register indexes,
// and the result item type. No dependencies.
`default_nettype none

package bws_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 13;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = 13'd8191;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [SUM_W-1:0] window_sum;
    logic             frame_last;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/box_window_sum_5x5.sv
// Top level of the streaming box window sum with zero padding.
// Depends on bws_pkg; holds the line memory, the column-sum pipeline and the
// two-entry result queue.
`default_nettype none

// Streaming WINDOW x WINDOW box sum, zero padded, not normalized. Feed pixels in
// raster order over an extended grid of (height + HALF) rows by (width + HALF)
// columns, HALF = (WINDOW-1)/2; the transfer at extended (r,c) yields the sum
// centred on (r-HALF, c-HALF) once both are non-negative, frame_last marking
// the final image position. Sustained rate is one pixel per clock while the
// result queue has room: each column is handled by one read-modify-write of a
// single line memory entry holding the WINDOW-1 earlier rows of that column,
// read at the transfer and written back the next cycle. Each result passes the
// stage 1 registers and then the result queue before out_valid_o rises.
// Sums above 8191 (larger windows) saturate. The line memory needs
// no clearing after reset; rows not yet written in a frame are masked.
// Writing width or height restarts the frame; write only while idle.

module box_window_sum_5x5 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WINDOW     = 5
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [bws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [bws_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire [bws_pkg::PIX_W-1:0]      pixel_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [bws_pkg::SUM_W-1:0]     window_sum_o,
  output logic                          frame_last_o
);
  import bws_pkg::*;

  localparam int HALF  = (WINDOW - 1) / 2;
  localparam int DEPTH = WINDOW - 1;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + WINDOW);
  localparam int RW    = $clog2(MAX_HEIGHT + WINDOW);
  localparam int VW    = PIX_W + $clog2(WINDOW + 1);
  localparam int SW    = PIX_W + $clog2(WINDOW * WINDOW + 1);
  localparam int MEM_W = DEPTH * PIX_W;

  localparam logic [CW-1:0] W_RST = CW'((MAX_WIDTH < 10) ? MAX_WIDTH : 10);
  localparam logic [RW-1:0] H_RST = RW'((MAX_HEIGHT < 8) ? MAX_HEIGHT : 8);

  // configuration and raster counters
  logic [CW-1:0] width_q, width_d;
  logic [RW-1:0] height_q, height_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  logic col_end, row_end;
  assign col_end = (col_q == width_q + CW'(HALF) - CW'(1));
  assign row_end = (row_q == height_q + RW'(HALF) - RW'(1));

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT)) begin
      if (cfg_idx_i == REG_WIDTH) begin
        if (cfg_wdata_i == '0) begin
          width_d = CW'(1);
        end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
          width_d = CW'(MAX_WIDTH);
        end else begin
          width_d = CW'(cfg_wdata_i);
        end
      end else begin
        if (cfg_wdata_i == '0) begin
          height_d = RW'(1);
        end else if (32'(cfg_wdata_i) > MAX_HEIGHT) begin
          height_d = RW'(MAX_HEIGHT);
        end else begin
          height_d = RW'(cfg_wdata_i);
        end
      end
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_RST;
      height_q <= H_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // per-transfer flags: row k above the current one lies in the image
  logic [DEPTH:0] mask_d;
  logic           col_in;
  assign col_in = (col_q < width_q);

  always_comb begin
    for (int k = 0; k <= DEPTH; k++) begin
      mask_d[k] = col_in && (row_q >= RW'(k)) && (row_q < height_q + RW'(k));
    end
  end

  // stage 1 registers
  logic              s1_valid_q, s1_wr_q;
  logic              s1_emit_q, s1_last_q, s1_czero_q;
  logic [DEPTH:0]    s1_mask_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [AW-1:0]     s1_addr_q;
  logic [MEM_W-1:0]  rd_q;

  logic [AW-1:0] rd_addr;
  assign rd_addr = col_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_wr_q    <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
      s1_wr_q    <= in_xfer && col_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_emit_q  <= (row_q >= RW'(HALF)) && (col_q >= CW'(HALF));
      s1_last_q  <= row_end && col_end;
      s1_czero_q <= (col_q == '0);
      s1_mask_q  <= mask_d;
      s1_pix_q   <= pixel_i;
      s1_addr_q  <= rd_addr;
    end
  end

  // line memory: entry c holds rows r-1 .. r-DEPTH of column c
  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] wr_data;

  generate
    if (DEPTH > 1) begin : g_shift
      assign wr_data = {rd_q[MEM_W-PIX_W-1:0], s1_pix_q};
    end else begin : g_single
      assign wr_data = s1_pix_q;
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= line_mem[rd_addr];
    end
    if (s1_wr_q) begin
      line_mem[s1_addr_q] <= wr_data;
    end
  end

  // column sum and horizontal window
  logic [VW-1:0] vsum;
  logic [VW-1:0] hist_q [DEPTH];
  logic [SW-1:0] wsum;
  logic          push, pop;

  always_comb begin
    vsum = s1_mask_q[0] ? VW'(s1_pix_q) : '0;
    for (int k = 1; k <= DEPTH; k++) begin
      if (s1_mask_q[k]) begin
        vsum = vsum + VW'(rd_q[(k-1)*PIX_W +: PIX_W]);
      end
    end
  end

  always_comb begin
    wsum = SW'(vsum);
    if (!s1_czero_q) begin
      for (int k = 0; k < DEPTH; k++) begin
        wsum = wsum + SW'(hist_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      hist_q[0] <= vsum;
      for (int k = 1; k < DEPTH; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  out_item_t res;
  always_comb begin
    res.window_sum = (wsum > SW'(SUM_MAX)) ? SUM_MAX : SUM_W'(wsum);
    res.frame_last = s1_last_q;
  end

  // two-entry result queue
  out_item_t   fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic [2:0]  occ;

  assign push = s1_valid_q && s1_emit_q;
  assign pop  = out_xfer;
  assign occ  = 3'(count_q) + 3'(push) - 3'(pop);

  assign in_ready_o   = (occ <= 3'd1);
  assign out_valid_o  = (count_q != 2'd0);
  assign window_sum_o = fifo_q[rd_ptr_q].window_sum;
  assign frame_last_o = fifo_q[rd_ptr_q].frame_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= occ[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  // checks
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s1_wr_q) |-> (rd_addr != s1_addr_q))
    else $error("line memory read and write hit the same column");

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("result queue overflow");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !push)
    else $error("result pushed into a full queue");

  a_col_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < width_q + CW'(HALF))
    else $error("column counter left the extended grid");

  a_emit_not_col0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_emit_q) |-> !s1_czero_q)
    else $error("result emitted at column zero");

endmodule

`default_nettype wire
